// File: sv/hrht_pkg.sv
package hrht_pkg;

    localparam int NUM_NAMES_DEF  = 8;
    localparam int NAME_CHARS_DEF = 16;
    localparam int TABLE_ROWS     = 16;
    localparam int NAME_BYTES     = 16;
    localparam int Q_DEPTH        = 4;

    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd3;
    localparam logic [2:0] KIND_BODY   = 3'd4;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam logic [1:0] REG_METHOD  = 2'd0;
    localparam logic [1:0] REG_TARGET  = 2'd1;
    localparam logic [1:0] REG_VERSION = 2'd2;

    localparam logic [3:0]  METHOD_LIMIT_RST  = 4'd9;
    localparam logic [10:0] TARGET_LIMIT_RST  = 11'd1023;
    localparam logic [5:0]  VERSION_LIMIT_RST = 6'd49;

    // Header names, lower case, last character in the low byte.
    localparam logic [NAME_BYTES*8-1:0] NAME_STR [TABLE_ROWS] = '{
        "host", "content-length", "content-type", "user-agent",
        "accept", "connection", "accept-encoding", "accept-language",
        "", "", "", "", "", "", "", ""
    };
    localparam logic [4:0] NAME_LEN [TABLE_ROWS] = '{
        5'd4, 5'd14, 5'd12, 5'd10, 5'd6, 5'd10, 5'd15, 5'd15,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic [3:0]  method_limit;
        logic [10:0] target_limit;
        logic [5:0]  version_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic [2:0] header_id;
        logic       field_end;
        logic [1:0] status;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_t;

    function automatic logic [4:0] name_len(input logic [3:0] row);
        return NAME_LEN[row];
    endfunction

    // Character at pos of a table name; zero past its end.
    function automatic logic [7:0] name_char(input logic [3:0] row, input logic [4:0] pos);
        logic [4:0]               len;
        logic [3:0]               back;
        logic [NAME_BYTES*8-1:0]  shifted;
        len = NAME_LEN[row];
        back = 4'(len - pos - 5'd1);
        shifted = NAME_STR[row] >> {back, 3'b000};
        if (pos < len) begin
            return shifted[7:0];
        end
        return 8'h00;
    endfunction

endpackage

// File: sv/hrht_cfg.sv
module hrht_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output hrht_pkg::cfg_t     cfg
);
    import hrht_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_METHOD:  cfg_next.method_limit  = pwdata[3:0];
                REG_TARGET:  cfg_next.target_limit  = pwdata[10:0];
                REG_VERSION: cfg_next.version_limit = pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_METHOD:  prdata = 32'(cfg_reg.method_limit);
            REG_TARGET:  prdata = 32'(cfg_reg.target_limit);
            REG_VERSION: prdata = 32'(cfg_reg.version_limit);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.method_limit  <= METHOD_LIMIT_RST;
            cfg_reg.target_limit  <= TARGET_LIMIT_RST;
            cfg_reg.version_limit <= VERSION_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/hrht_core.sv
module hrht_core #(
    parameter int NUM_NAMES  = hrht_pkg::NUM_NAMES_DEF,
    parameter int NAME_CHARS = hrht_pkg::NAME_CHARS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             start_of_request,
    input  hrht_pkg::cfg_t   cfg,
    output hrht_pkg::step_t  step
);
    import hrht_pkg::*;

    localparam int HDR_W = (NUM_NAMES > 1) ? $clog2(NUM_NAMES) : 1;

    typedef enum logic [2:0] {PH_LINE, PH_NAME, PH_VALUE, PH_BODY, PH_BAD} phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [1:0]           tok_idx;
        logic [10:0]          tok_len;
        logic [4:0]           name_pos;
        logic [NUM_NAMES-1:0] mask;
        logic                 hdr_hit;
        logic [HDR_W-1:0]     hdr_id;
        logic                 pending_cr;
        logic                 line_start;
    } st_t;

    typedef struct packed {
        st_t  st;
        logic hit;
        res_t res;
    } op_t;

    localparam st_t ST_RST = '{
        phase: PH_LINE, tok_idx: 2'd0, tok_len: 11'd0, name_pos: 5'd0,
        mask: '1, hdr_hit: 1'b0, hdr_id: '0, pending_cr: 1'b0, line_start: 1'b1
    };

    st_t st_reg;
    st_t st_next;

    function automatic res_t mk(input logic [7:0] b, input logic v, input logic [2:0] kind,
                                input logic [2:0] id, input logic fend, input logic [1:0] stat);
        res_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.field_kind = kind;
        r.header_id  = id;
        r.field_end  = fend;
        r.status     = stat;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] id3(input logic [HDR_W-1:0] id);
        logic [3:0] wide;
        wide = 4'(id);
        return wide[2:0];
    endfunction

    function automatic st_t new_line(input st_t s);
        st_t o;
        o = s;
        o.phase      = PH_NAME;
        o.name_pos   = 5'd0;
        o.mask       = '1;
        o.hdr_hit    = 1'b0;
        o.line_start = 1'b1;
        return o;
    endfunction

    function automatic op_t do_bad(input st_t s);
        op_t o;
        o.st       = s;
        o.st.phase = PH_BAD;
        o.hit      = 1'b1;
        o.res      = mk(8'h00, 1'b0, KIND_METHOD, 3'd0, 1'b0, ST_BAD);
        return o;
    endfunction

    function automatic op_t do_content(input st_t s, input logic [7:0] c, input cfg_t lims);
        op_t              o;
        logic [10:0]      lim;
        logic [7:0]       lc;
        logic             found;
        logic [HDR_W-1:0] id;
        o.st  = s;
        o.hit = 1'b0;
        o.res = '0;
        lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
        case (s.phase)
            PH_LINE: begin
                if (s.tok_idx != 2'd3) begin
                    if (c == CH_SPACE) begin
                        if (s.tok_len != 11'd0) begin
                            o.hit = 1'b1;
                            o.res = mk(8'h00, 1'b0, {1'b0, s.tok_idx}, 3'd0, 1'b1, ST_NORMAL);
                            o.st.tok_idx = s.tok_idx + 2'd1;
                            o.st.tok_len = 11'd0;
                        end
                    end else begin
                        case (s.tok_idx)
                            2'd0:    lim = 11'(lims.method_limit);
                            2'd1:    lim = lims.target_limit;
                            default: lim = 11'(lims.version_limit);
                        endcase
                        if (s.tok_len < lim) begin
                            o.hit = 1'b1;
                            o.res = mk(c, 1'b1, {1'b0, s.tok_idx}, 3'd0, 1'b0, ST_NORMAL);
                        end
                        if (s.tok_len != 11'h7ff) begin
                            o.st.tok_len = s.tok_len + 11'd1;
                        end
                    end
                end
            end
            PH_NAME: begin
                o.st.line_start = 1'b0;
                if (c == CH_COLON) begin
                    found = 1'b0;
                    id    = '0;
                    // lowest matching row wins
                    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
                        if (s.mask[k] && s.name_pos != 5'd0 &&
                            s.name_pos >= name_len(4'(k))) begin
                            found = 1'b1;
                            id    = HDR_W'(k);
                        end
                    end
                    o.st.hdr_hit = found;
                    o.st.hdr_id  = id;
                    o.st.phase   = PH_VALUE;
                end else begin
                    if (6'(s.name_pos) >= 6'(NAME_CHARS) || s.name_pos == 5'd31) begin
                        o.st.mask = '0;
                    end else begin
                        for (int k = 0; k < NUM_NAMES; k++) begin
                            if (name_char(4'(k), s.name_pos) != lc) begin
                                o.st.mask[k] = 1'b0;
                            end
                        end
                    end
                    if (s.name_pos != 5'd31) begin
                        o.st.name_pos = s.name_pos + 5'd1;
                    end
                end
            end
            PH_VALUE: begin
                if (s.hdr_hit) begin
                    o.hit = 1'b1;
                    o.res = mk(c, 1'b1, KIND_HEADER, id3(s.hdr_id), 1'b0, ST_NORMAL);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic op_t do_line_end(input st_t s);
        op_t o;
        o.st  = s;
        o.hit = 1'b0;
        o.res = '0;
        case (s.phase)
            PH_LINE: begin
                if (s.tok_idx != 2'd3 && s.tok_len != 11'd0) begin
                    o.hit = 1'b1;
                    o.res = mk(8'h00, 1'b0, {1'b0, s.tok_idx}, 3'd0, 1'b1, ST_NORMAL);
                end
                o.st = new_line(s);
            end
            PH_NAME: begin
                if (s.line_start) begin
                    o.hit      = 1'b1;
                    o.res      = mk(8'h00, 1'b0, KIND_BODY, 3'd0, 1'b0, ST_DONE);
                    o.st.phase = PH_BODY;
                end else begin
                    o = do_bad(s);
                end
            end
            PH_VALUE: begin
                if (s.hdr_hit) begin
                    o.hit = 1'b1;
                    o.res = mk(8'h00, 1'b0, KIND_HEADER, id3(s.hdr_id), 1'b1, ST_NORMAL);
                end
                o.st = new_line(s);
            end
            default: ;
        endcase
        return o;
    endfunction

    always_comb begin
        st_t  s0;
        st_t  s1;
        op_t  opa;
        op_t  opb;
        logic done;
        s0 = start_of_request ? ST_RST : st_reg;
        s1 = s0;
        done = 1'b0;
        opa.st = s0;
        opa.hit = 1'b0;
        opa.res = '0;
        opb = opa;
        if (s0.phase == PH_BODY) begin
            opa.hit = 1'b1;
            opa.res = mk(in_byte, 1'b1, KIND_BODY, 3'd0, 1'b0, ST_NORMAL);
            opb.st  = s0;
        end else if (s0.phase != PH_BAD) begin
            // a held CR either closes the line or goes out as data first
            if (s0.pending_cr) begin
                s1.pending_cr = 1'b0;
                if (in_byte == CH_LF) begin
                    opa  = do_line_end(s1);
                    done = 1'b1;
                end else begin
                    opa = do_content(s1, CH_CR, cfg);
                end
            end else begin
                opa.st = s1;
            end
            opb.st = opa.st;
            if (!done && opa.st.phase != PH_BAD) begin
                if (in_byte == CH_CR) begin
                    opb.st.pending_cr = 1'b1;
                end else if (in_byte == CH_NUL) begin
                    opb = do_bad(opa.st);
                end else begin
                    opb = do_content(opa.st, in_byte, cfg);
                end
            end
        end
        step = '0;
        if (opa.hit && opb.hit) begin
            step.count       = 2'd2;
            step.first       = opa.res;
            step.second      = opb.res;
            step.second.last = 1'b1;
        end else if (opa.hit || opb.hit) begin
            step.count      = 2'd1;
            step.first      = opa.hit ? opa.res : opb.res;
            step.first.last = 1'b1;
        end
        st_next = accept ? opb.st : st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RST;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// File: sv/hrht_queue.sv
module hrht_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_en,
    input  hrht_pkg::step_t  push,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output hrht_pkg::res_t   m_res
);
    import hrht_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    res_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic [1:0]       n_push;
    logic             pop;

    assign n_push  = push_en ? push.count : 2'd0;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid & m_ready;
    assign m_res   = mem[rp_reg];
    // keep space for the two beats one byte can produce
    assign room    = (cnt_reg <= (PTR_W+1)'(Q_DEPTH - 2));

    always_comb begin
        wp_next  = wp_reg + PTR_W'(n_push);
        rp_next  = rp_reg + PTR_W'(pop);
        cnt_next = cnt_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wp_reg] <= push.first;
        end
        if (n_push == 2'd2) begin
            mem[wp_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: sv/http_request_head_tokenizer.sv
// HTTP request head tokenizer.
// Input stream: one request byte per beat on s_tdata; s_tuser high restarts
// the parser at the request line before that byte is taken.
// Output stream: one token byte or marker per beat. m_tdata carries the
// byte, the end-of-field flag and the status; m_tuser carries the data-valid
// flag, the field kind and the header number; m_tlast marks the final beat
// that one input byte produces.
// Throughput: one byte per cycle while s_tready is high; a byte that follows
// a lone CR can yield two beats, which the four-entry output queue absorbs.
// s_tready drops while the queue holds more than two beats, so a stalled
// receiver backs up into the sender without losing or repeating beats.
// Limits for method, target and version length are written over APB at
// byte addresses 0, 4 and 8; the user must do so only while the stream is
// idle, which the block itself does not enforce.
// Reset clears the parser to the request line, empties the queue and loads
// the limits 9, 1023 and 49.
module http_request_head_tokenizer #(
    parameter int NUM_NAMES  = hrht_pkg::NUM_NAMES_DEF,
    parameter int NAME_CHARS = hrht_pkg::NAME_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // start_of_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] field_end, [10:9] status
    output logic [6:0]  m_tuser,   // [0] byte_valid, [3:1] field_kind, [6:4] header_id
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrht_pkg::*;

    cfg_t  cfg;
    step_t step;
    res_t  q_res;
    logic  accept;
    logic  room;

    assign s_tready = room;
    assign accept   = s_tvalid & room;

    hrht_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hrht_core #(
        .NUM_NAMES  (NUM_NAMES),
        .NAME_CHARS (NAME_CHARS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .in_byte          (s_tdata),
        .start_of_request (s_tuser),
        .cfg              (cfg),
        .step             (step)
    );

    hrht_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (accept),
        .push    (step),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (q_res)
    );

    assign m_tdata = {5'b00000, q_res.status, q_res.field_end, q_res.out_byte};
    assign m_tuser = {q_res.header_id, q_res.field_kind, q_res.byte_valid};
    assign m_tlast = q_res.last;

endmodule
